[design/cepf_pkg.sv]
// Shared types and constants for the circle exclusion point filter.
// No dependencies; imported by the filter and its port checker.
package cepf_pkg;

    localparam int MAX_REGIONS_DEF = 2048;

    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;

    // 1.0 in Q23.8
    localparam logic [RADIUS_W-1:0] RADIUS_FLOOR = RADIUS_W'(256);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEST   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

endpackage

[design/circle_exclusion_point_filter.sv]
// Circle exclusion point filter: clearing table in one synchronous RAM,
// scanned through a four-stage distance pipeline. Depends on cepf_pkg.
//
// Usage:
//   Commands enter on start/i_operation/i_pos_*/i_radius_in and are taken at
//   an edge where start is high and busy is low.
//   Clear and append finish in the accepting cycle; busy stays low.
//   A point test raises busy and reads one stored clearing per cycle from the
//   table RAM. Each entry passes through read, subtract, magnitude, square and
//   compare stages. The scan stops issuing at the first hit.
//   Busy ends sooner on an early hit; the table RAM's single read port sets
//   the one entry per cycle.
//   A kept point shows on o_kept_x/y/z with o_strobe high for one cycle, the
//   cycle in which busy has just dropped. A dropped point gives no beat.
//   The receiver cannot stall; each beat is valid for exactly one cycle.
//   Reset empties the table (count to zero) and returns to idle; the RAM
//   contents are not cleared and need no clearing pass.
module circle_exclusion_point_filter #(
    parameter int MAX_REGIONS = cepf_pkg::MAX_REGIONS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_operation,
    input  logic signed [cepf_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [cepf_pkg::COORD_W-1:0] i_pos_y,
    input  logic signed [cepf_pkg::COORD_W-1:0] i_pos_z,
    input  logic [cepf_pkg::RADIUS_W-1:0]       i_radius_in,
    output logic                                o_strobe,
    output logic signed [cepf_pkg::COORD_W-1:0] o_kept_x,
    output logic signed [cepf_pkg::COORD_W-1:0] o_kept_y,
    output logic signed [cepf_pkg::COORD_W-1:0] o_kept_z
);
    import cepf_pkg::*;

    localparam int AW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW    = $clog2(MAX_REGIONS + 1);
    localparam int ENT_W = 2 * COORD_W + RADIUS_W;
    localparam int SQ_W  = 2 * COORD_W;
    localparam int R2_W  = 2 * RADIUS_W;

    t_state r_state, n_state;

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic               r_hit;
    logic [COORD_W-1:0] r_px, r_py, r_pz;

    logic [ENT_W-1:0] mem [MAX_REGIONS];
    logic [ENT_W-1:0] r_rd_data;

    // pipeline stage registers
    logic                r_v1, r_v2, r_v3, r_v4;
    logic [COORD_W:0]    r_dx, r_dy;
    logic [RADIUS_W-1:0] r_rf2, r_rf3;
    logic [COORD_W-1:0]  r_mx, r_my;
    logic [SQ_W-1:0]     r_sqx, r_sqy;
    logic [R2_W-1:0]     r_r2;

    logic accept, issue, wr_en, clr_en, pipe_empty, n_strobe, hit4;
    logic [COORD_W-1:0]  rd_cx, rd_cy;
    logic [RADIUS_W-1:0] rd_r;
    logic [SQ_W:0]       dist_sum;

    assign accept     = start && (r_state == ST_IDLE);
    assign pipe_empty = !(r_v1 || r_v2 || r_v3 || r_v4);

    assign rd_cx = r_rd_data[ENT_W-1 -: COORD_W];
    assign rd_cy = r_rd_data[RADIUS_W +: COORD_W];
    assign rd_r  = r_rd_data[RADIUS_W-1:0];

    assign dist_sum = {1'b0, r_sqx} + {1'b0, r_sqy};
    // a carry out of the 64-bit sum always means outside
    assign hit4     = r_v4 && (dist_sum <= {{(SQ_W + 1 - R2_W){1'b0}}, r_r2});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start && (i_operation == OP_TEST)) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_hit || (r_idx >= r_count)) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (pipe_empty) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        issue    = (r_state == ST_SCAN) && !r_hit && (r_idx < r_count);
        n_strobe = (r_state == ST_DRAIN) && pipe_empty && !r_hit;
        wr_en    = accept && (i_operation == OP_APPEND) && (r_count < CW'(MAX_REGIONS));
        clr_en   = accept && (i_operation == OP_CLEAR);
    end

    assign busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= n_strobe;
            r_v1     <= issue;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_v4     <= r_v3;
            if (clr_en) begin
                r_count <= '0;
            end else if (wr_en) begin
                r_count <= r_count + CW'(1);
            end
            if (accept) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else begin
                if (issue) r_idx <= r_idx + CW'(1);
                if (hit4) r_hit <= 1'b1;
            end
        end
    end

    // table RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[AW-1:0]] <= {i_pos_x, i_pos_y, i_radius_in};
        end
        r_rd_data <= mem[r_idx[AW-1:0]];
    end

    // point capture and distance datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_pz <= i_pos_z;
        end
        r_dx  <= {r_px[COORD_W-1], r_px} - {rd_cx[COORD_W-1], rd_cx};
        r_dy  <= {r_py[COORD_W-1], r_py} - {rd_cy[COORD_W-1], rd_cy};
        r_rf2 <= (rd_r < RADIUS_FLOOR) ? RADIUS_FLOOR : rd_r;
        // magnitude of a 33-bit difference fits in 32 bits
        r_mx  <= r_dx[COORD_W] ? COORD_W'(-r_dx) : r_dx[COORD_W-1:0];
        r_my  <= r_dy[COORD_W] ? COORD_W'(-r_dy) : r_dy[COORD_W-1:0];
        r_rf3 <= r_rf2;
        r_sqx <= SQ_W'(r_mx) * SQ_W'(r_mx);
        r_sqy <= SQ_W'(r_my) * SQ_W'(r_my);
        r_r2  <= R2_W'(r_rf3) * R2_W'(r_rf3);
    end

    assign o_kept_x = r_px;
    assign o_kept_y = r_py;
    assign o_kept_z = r_pz;

endmodule

[design/cepf_port_checker.sv]
// Port-level checker for the circle exclusion point filter, with its bind.
// Depends on cepf_pkg and the top level's ports.
module cepf_port_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_operation,
    input logic       o_strobe
);
    import cepf_pkg::*;

    logic test_beat, other_beat;
    assign test_beat  = start && !busy && (i_operation == OP_TEST);
    assign other_beat = start && !busy && (i_operation != OP_TEST);

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    a_strobe_ends_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $fell(busy))
        else $error("result beat without a test just finishing");

    a_test_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        test_beat |=> busy)
        else $error("accepted point test did not raise busy");

    a_table_cmd_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        other_beat |=> (!busy && !o_strobe))
        else $error("table command raised busy or produced a beat");

endmodule

bind circle_exclusion_point_filter cepf_port_checker u_cepf_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_operation (i_operation),
    .o_strobe    (o_strobe)
);
